### hw/rtl/cpu_jump_call_return_unit_assert.svh
// assertion macros shared by the jump/call/return unit modules
// expects clk and rst_n in the scope where a macro is used
`ifndef CPU_JUMP_CALL_RETURN_UNIT_ASSERT_SVH
`define CPU_JUMP_CALL_RETURN_UNIT_ASSERT_SVH

// expression holds at every clock edge out of reset
`define CJR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CJR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/cjr_pkg.sv
// shared types and constants of the jump/call/return unit
// no dependencies
package cjr_pkg;

  // result kinds
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ILLEGAL = 2'd3;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // opcodes
  localparam logic [7:0] OP_JSR_ABS  = 8'h20;
  localparam logic [7:0] OP_JSL      = 8'h22;
  localparam logic [7:0] OP_JMP_ABS  = 8'h4c;
  localparam logic [7:0] OP_JML      = 8'h5c;
  localparam logic [7:0] OP_RTS      = 8'h60;
  localparam logic [7:0] OP_RTL      = 8'h6b;
  localparam logic [7:0] OP_JMP_IND  = 8'h6c;
  localparam logic [7:0] OP_JMP_IDX  = 8'h7c;
  localparam logic [7:0] OP_JML_IND  = 8'hdc;
  localparam logic [7:0] OP_JSR_IDX  = 8'hfc;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // one queued transaction worth of results: stack writes then one tail result
  typedef struct packed {
    logic [1:0]  n_wr;       // number of stack writes, 0..3
    logic [15:0] wr_sp;      // stack pointer of the first write
    logic [23:0] wr_data;    // write bytes, first written byte in [7:0]
    logic [1:0]  tail_kind;  // read, done or illegal
    logic [23:0] tail_addr;
    logic [15:0] tail_pc;
    logic [7:0]  tail_bank;
    logic [15:0] tail_sp;
  } desc_t;

endpackage

### hw/rtl/cpu_jump_call_return_unit.sv
// Jump, call and return unit for the ten 16-bit CPU branch opcodes (JSR, JSL, JMP, JML,
// RTS, RTL and the indirect forms). A start transaction (command 0) carries the opcode and
// CPU state; the unit answers with stack-write requests (bank 0, high byte first, pointer
// decrementing), memory-read requests, and finally a done result with the new PC, bank and
// stack pointer, or one illegal result for any other opcode. Each read request is answered
// by a data transaction (command 1); data while no read is pending is dropped. The last
// result of each transaction has out_last set. The front end decodes one transaction per
// clock and places a descriptor in a small queue; the back end emits one result per clock
// from the queue head into an output register while out_stall is low. A transaction is accepted
// every cycle while the queue has room; a start produces k results (1 to 4), so the output
// port, at one result per clock, sets the sustained rate. A descriptor passes through a
// queue slot and then the output register before its first result appears.
// depends on cjr_pkg, cjr_front, cjr_queue, cjr_back
module cpu_jump_call_return_unit #(
  parameter int QUEUE_DEPTH = cjr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_opcode,
  input  logic [23:0] in_operand_bytes,
  input  logic [15:0] in_operand_address,
  input  logic [7:0]  in_program_bank,
  input  logic [15:0] in_stack_pointer,
  input  logic [15:0] in_index_x,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [23:0] out_bus_address,
  output logic [7:0]  out_write_byte,
  output logic [15:0] out_new_pc,
  output logic [7:0]  out_new_bank,
  output logic [15:0] out_new_sp,
  output logic        out_last
);
  import cjr_pkg::*;

  desc_t push_desc;
  desc_t head_desc;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  logic  q_full;

  // decode front end
  cjr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_opcode         (in_opcode),
    .in_operand_bytes  (in_operand_bytes),
    .in_operand_address(in_operand_address),
    .in_program_bank   (in_program_bank),
    .in_stack_pointer  (in_stack_pointer),
    .in_index_x        (in_index_x),
    .in_read_data      (in_read_data),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_desc            (push_desc)
  );

  // descriptor queue
  cjr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (q_push),
    .din_i  (push_desc),
    .pop_i  (q_pop),
    .head_o (head_desc),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // result back end
  cjr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_i         (head_desc),
    .empty_i        (q_empty),
    .pop_o          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_bus_address(out_bus_address),
    .out_write_byte (out_write_byte),
    .out_new_pc     (out_new_pc),
    .out_new_bank   (out_new_bank),
    .out_new_sp     (out_new_sp),
    .out_last       (out_last)
  );

endmodule

### hw/rtl/cjr_front.sv
// front end: accepts transactions, decodes opcodes, tracks pending reads
// builds at most one result descriptor per transaction; uses cjr_pkg
module cjr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [7:0]         in_opcode,
  input  logic [23:0]        in_operand_bytes,
  input  logic [15:0]        in_operand_address,
  input  logic [7:0]         in_program_bank,
  input  logic [15:0]        in_stack_pointer,
  input  logic [15:0]        in_index_x,
  input  logic [7:0]         in_read_data,
  input  logic               q_full,
  output logic               q_push,
  output cjr_pkg::desc_t     q_desc
);
  import cjr_pkg::*;

  logic        busy_r, busy_nxt;
  logic [7:0]  pend_op_r, pend_op_nxt;
  logic [1:0]  bytes_read_r, bytes_read_nxt;
  logic [23:0] gathered_r, gathered_nxt;
  logic [23:0] ptr_r, ptr_nxt;
  logic [7:0]  saved_bank_r, saved_bank_nxt;
  logic [15:0] saved_sp_r, saved_sp_nxt;

  logic        accept;
  logic [15:0] ret1, ret2, idx_addr;
  logic [1:0]  n_cnt;
  logic        need_three;
  logic [23:0] merged;
  logic [15:0] word;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // return addresses and indexed pointer
  assign ret1     = in_operand_address + 16'd1;
  assign ret2     = in_operand_address + 16'd2;
  assign idx_addr = in_operand_bytes[15:0] + in_index_x;

  // read data merge
  assign n_cnt      = bytes_read_r + 2'd1;
  assign need_three = (pend_op_r == OP_RTL) || (pend_op_r == OP_JML_IND);
  always_comb begin
    merged = gathered_r;
    case (bytes_read_r)
      2'd0:    merged[7:0]   = gathered_r[7:0] | in_read_data;
      2'd1:    merged[15:8]  = gathered_r[15:8] | in_read_data;
      2'd2:    merged[23:16] = gathered_r[23:16] | in_read_data;
      default: merged = gathered_r;
    endcase
  end
  assign word = merged[15:0];

  // decode and next state
  always_comb begin
    busy_nxt       = busy_r;
    pend_op_nxt    = pend_op_r;
    bytes_read_nxt = bytes_read_r;
    gathered_nxt   = gathered_r;
    ptr_nxt        = ptr_r;
    saved_bank_nxt = saved_bank_r;
    saved_sp_nxt   = saved_sp_r;
    q_push         = 1'b0;
    q_desc         = '0;
    if (accept) begin
      if (in_command == CMD_START) begin
        q_push         = 1'b1;
        busy_nxt       = 1'b0;
        bytes_read_nxt = 2'd0;
        gathered_nxt   = 24'd0;
        case (in_opcode)
          OP_JSR_ABS: begin
            q_desc.n_wr      = 2'd2;
            q_desc.wr_sp     = in_stack_pointer;
            q_desc.wr_data   = {8'h00, ret1[7:0], ret1[15:8]};
            q_desc.tail_kind = KIND_DONE;
            q_desc.tail_pc   = in_operand_bytes[15:0];
            q_desc.tail_bank = in_program_bank;
            q_desc.tail_sp   = in_stack_pointer - 16'd2;
          end
          OP_JSL: begin
            q_desc.n_wr      = 2'd3;
            q_desc.wr_sp     = in_stack_pointer;
            q_desc.wr_data   = {ret2[7:0], ret2[15:8], in_program_bank};
            q_desc.tail_kind = KIND_DONE;
            q_desc.tail_pc   = in_operand_bytes[15:0];
            q_desc.tail_bank = in_operand_bytes[23:16];
            q_desc.tail_sp   = in_stack_pointer - 16'd3;
          end
          OP_JMP_ABS: begin
            q_desc.tail_kind = KIND_DONE;
            q_desc.tail_pc   = in_operand_bytes[15:0];
            q_desc.tail_bank = in_program_bank;
            q_desc.tail_sp   = in_stack_pointer;
          end
          OP_JML: begin
            q_desc.tail_kind = KIND_DONE;
            q_desc.tail_pc   = in_operand_bytes[15:0];
            q_desc.tail_bank = in_operand_bytes[23:16];
            q_desc.tail_sp   = in_stack_pointer;
          end
          OP_RTS, OP_RTL: begin
            busy_nxt         = 1'b1;
            pend_op_nxt      = in_opcode;
            ptr_nxt          = {8'h00, in_stack_pointer + 16'd1};
            saved_bank_nxt   = in_program_bank;
            saved_sp_nxt     = (in_opcode == OP_RTL) ? in_stack_pointer + 16'd3
                                                     : in_stack_pointer + 16'd2;
            q_desc.tail_kind = KIND_READ;
            q_desc.tail_addr = {8'h00, in_stack_pointer + 16'd1};
          end
          OP_JMP_IND, OP_JML_IND: begin
            busy_nxt         = 1'b1;
            pend_op_nxt      = in_opcode;
            ptr_nxt          = {8'h00, in_operand_bytes[15:0]};
            saved_bank_nxt   = in_program_bank;
            saved_sp_nxt     = in_stack_pointer;
            q_desc.tail_kind = KIND_READ;
            q_desc.tail_addr = {8'h00, in_operand_bytes[15:0]};
          end
          OP_JMP_IDX: begin
            busy_nxt         = 1'b1;
            pend_op_nxt      = in_opcode;
            ptr_nxt          = {in_program_bank, idx_addr};
            saved_bank_nxt   = in_program_bank;
            saved_sp_nxt     = in_stack_pointer;
            q_desc.tail_kind = KIND_READ;
            q_desc.tail_addr = {in_program_bank, idx_addr};
          end
          OP_JSR_IDX: begin
            busy_nxt         = 1'b1;
            pend_op_nxt      = in_opcode;
            ptr_nxt          = {in_program_bank, idx_addr};
            saved_bank_nxt   = in_program_bank;
            saved_sp_nxt     = in_stack_pointer - 16'd2;
            q_desc.n_wr      = 2'd2;
            q_desc.wr_sp     = in_stack_pointer;
            q_desc.wr_data   = {8'h00, ret1[7:0], ret1[15:8]};
            q_desc.tail_kind = KIND_READ;
            q_desc.tail_addr = {in_program_bank, idx_addr};
          end
          default: begin
            pend_op_nxt      = 8'h00;
            q_desc.tail_kind = KIND_ILLEGAL;
          end
        endcase
      end else if (busy_r) begin
        q_push       = 1'b1;
        gathered_nxt = merged;
        if ((!need_three && n_cnt < 2'd2) || (need_three && n_cnt < 2'd3)) begin
          bytes_read_nxt   = n_cnt;
          q_desc.tail_kind = KIND_READ;
          q_desc.tail_addr = {ptr_r[23:16], ptr_r[15:0] + {14'd0, n_cnt}};
        end else begin
          busy_nxt         = 1'b0;
          bytes_read_nxt   = 2'd0;
          q_desc.tail_kind = KIND_DONE;
          q_desc.tail_sp   = saved_sp_r;
          case (pend_op_r)
            OP_RTS: begin
              q_desc.tail_pc   = word + 16'd1;
              q_desc.tail_bank = saved_bank_r;
            end
            OP_RTL: begin
              q_desc.tail_pc   = word + 16'd1;
              q_desc.tail_bank = merged[23:16];
            end
            OP_JML_IND: begin
              q_desc.tail_pc   = word;
              q_desc.tail_bank = merged[23:16];
            end
            default: begin
              q_desc.tail_pc   = word;
              q_desc.tail_bank = saved_bank_r;
            end
          endcase
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_op_r    <= 8'h00;
      bytes_read_r <= 2'd0;
    end else begin
      busy_r       <= busy_nxt;
      pend_op_r    <= pend_op_nxt;
      bytes_read_r <= bytes_read_nxt;
    end
  end

  // pointer and gathered bytes
  always_ff @(posedge clk) begin
    gathered_r   <= gathered_nxt;
    ptr_r        <= ptr_nxt;
    saved_bank_r <= saved_bank_nxt;
    saved_sp_r   <= saved_sp_nxt;
  end

endmodule

### hw/rtl/cjr_queue.sv
// small descriptor queue between the front and back ends
// uses cjr_pkg and the shared assertion macros
module cjr_queue #(
  parameter int DEPTH = cjr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  cjr_pkg::desc_t     din_i,
  input  logic               pop_i,
  output cjr_pkg::desc_t     head_o,
  output logic               empty_o,
  output logic               full_o
);
  import cjr_pkg::*;
  `include "cpu_jump_call_return_unit_assert.svh"

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  desc_t             slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == FullCnt);
  assign head_o  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // descriptor storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= din_i;
    end
  end

  `CJR_ASSERT_IMPLY(a_no_overflow, push_i, !full_o, "queue push while full")
  `CJR_ASSERT_IMPLY(a_no_underflow, pop_i, !empty_o, "queue pop while empty")
  `CJR_ASSERT_ALWAYS(a_count_range, count_r <= FullCnt, "queue count out of range")

endmodule

### hw/rtl/cjr_back.sv
// back end: expands descriptors into results, one per cycle while the output is not stalled, into an output register
// uses cjr_pkg and the shared assertion macros
module cjr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cjr_pkg::desc_t     head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [23:0]        out_bus_address,
  output logic [7:0]         out_write_byte,
  output logic [15:0]        out_new_pc,
  output logic [7:0]         out_new_bank,
  output logic [15:0]        out_new_sp,
  output logic               out_last
);
  import cjr_pkg::*;
  `include "cpu_jump_call_return_unit_assert.svh"

  logic [1:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [7:0]  wbyte_r, wbyte_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  bank_r, bank_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic        is_tail;
  logic [15:0] wr_addr;
  logic [7:0]  wr_byte;

  assign load    = !valid_r || !out_stall;
  assign is_tail = (step_r == head_i.n_wr);
  assign wr_addr = head_i.wr_sp - {14'd0, step_r};

  // byte of the current stack write
  always_comb begin
    case (step_r)
      2'd0:    wr_byte = head_i.wr_data[7:0];
      2'd1:    wr_byte = head_i.wr_data[15:8];
      2'd2:    wr_byte = head_i.wr_data[23:16];
      default: wr_byte = 8'h00;
    endcase
  end

  // next result and sequencing
  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    wbyte_nxt = wbyte_r;
    pc_nxt    = pc_r;
    bank_nxt  = bank_r;
    sp_nxt    = sp_r;
    last_nxt  = last_r;
    pop_o     = 1'b0;
    if (load) begin
      valid_nxt = !empty_i;
      if (!empty_i) begin
        if (is_tail) begin
          kind_nxt  = head_i.tail_kind;
          addr_nxt  = head_i.tail_addr;
          wbyte_nxt = 8'h00;
          pc_nxt    = head_i.tail_pc;
          bank_nxt  = head_i.tail_bank;
          sp_nxt    = head_i.tail_sp;
          last_nxt  = 1'b1;
          step_nxt  = 2'd0;
          pop_o     = 1'b1;
        end else begin
          kind_nxt  = KIND_WRITE;
          addr_nxt  = {8'h00, wr_addr};
          wbyte_nxt = wr_byte;
          pc_nxt    = 16'd0;
          bank_nxt  = 8'h00;
          sp_nxt    = 16'd0;
          last_nxt  = 1'b0;
          step_nxt  = step_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    addr_r  <= addr_nxt;
    wbyte_r <= wbyte_nxt;
    pc_r    <= pc_nxt;
    bank_r  <= bank_nxt;
    sp_r    <= sp_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_bus_address = addr_r;
  assign out_write_byte  = wbyte_r;
  assign out_new_pc      = pc_r;
  assign out_new_bank    = bank_r;
  assign out_new_sp      = sp_r;
  assign out_last        = last_r;

  `CJR_ASSERT_IMPLY(a_step_needs_head, step_r != 2'd0, !empty_i,
    "write sequence in progress with no descriptor")
  `CJR_ASSERT_IMPLY(a_step_in_range, !empty_i, step_r <= head_i.n_wr,
    "write step beyond descriptor")
  `CJR_ASSERT_IMPLY(a_last_on_tail, valid_r, last_r == (kind_r != KIND_WRITE),
    "last flag does not match result kind")

endmodule

### sim/cpu_jump_call_return_unit_test.sv
// testbench for cpu_jump_call_return_unit: directed and random jump, call and return traffic
// predicts every result in-line and checks the result port field by field
// depends on cjr_pkg and cpu_jump_call_return_unit
`timescale 1ns / 1ps

module cpu_jump_call_return_unit_test;
  import cjr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] addr;
    logic [7:0]  wbyte;
    logic [15:0] pc;
    logic [7:0]  bank;
    logic [15:0] sp;
    logic        last;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_opcode;
  logic [23:0] in_operand_bytes;
  logic [15:0] in_operand_address;
  logic [7:0]  in_program_bank;
  logic [15:0] in_stack_pointer;
  logic [15:0] in_index_x;
  logic [7:0]  in_read_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [23:0] out_bus_address;
  logic [7:0]  out_write_byte;
  logic [15:0] out_new_pc;
  logic [7:0]  out_new_bank;
  logic [15:0] out_new_sp;
  logic        out_last;

  // shadow state of the instruction that waits for read data
  logic [7:0]  pend_op;
  logic        fetch_busy;
  logic [1:0]  fetch_count;
  logic [23:0] fetched_bytes;
  logic [23:0] fetch_ptr;
  logic [7:0]  keep_bank;
  logic [15:0] keep_sp;

  bus_result_t expected_bus_results[$];
  int          mismatch_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  logic [7:0] branch_ops [0:9] = '{OP_JSR_ABS, OP_JSL, OP_JMP_ABS, OP_JML, OP_RTS,
                                   OP_RTL, OP_JMP_IND, OP_JMP_IDX, OP_JML_IND, OP_JSR_IDX};

  cpu_jump_call_return_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_opcode(in_opcode), .in_operand_bytes(in_operand_bytes),
    .in_operand_address(in_operand_address), .in_program_bank(in_program_bank),
    .in_stack_pointer(in_stack_pointer), .in_index_x(in_index_x),
    .in_read_data(in_read_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_bus_address(out_bus_address), .out_write_byte(out_write_byte),
    .out_new_pc(out_new_pc), .out_new_bank(out_new_bank), .out_new_sp(out_new_sp),
    .out_last(out_last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result builders
  function automatic bus_result_t stack_write(input logic [15:0] sp, input logic [7:0] b);
    bus_result_t r;
    r = '0;
    r.kind  = KIND_WRITE;
    r.addr  = {8'h00, sp};
    r.wbyte = b;
    return r;
  endfunction

  function automatic bus_result_t bus_read(input logic [23:0] addr);
    bus_result_t r;
    r = '0;
    r.kind = KIND_READ;
    r.addr = addr;
    return r;
  endfunction

  function automatic bus_result_t branch_done(input logic [15:0] pc, input logic [7:0] bank,
                                              input logic [15:0] sp);
    bus_result_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.pc   = pc;
    r.bank = bank;
    r.sp   = sp;
    return r;
  endfunction

  // arm the pointer fetch and give its first read
  function automatic bus_result_t start_fetch(input logic [7:0] op, input logic [23:0] addr,
                                              input logic [7:0] pb, input logic [15:0] fsp);
    pend_op     = op;
    fetch_busy  = 1'b1;
    fetch_count = 2'd0;
    fetched_bytes = 24'h0;
    fetch_ptr   = addr;
    keep_bank   = pb;
    keep_sp     = fsp;
    return bus_read(addr);
  endfunction

  function automatic int fetch_length(input logic [7:0] op);
    return (op == OP_RTL || op == OP_JML_IND) ? 3 : 2;
  endfunction

  // expected results of one accepted transaction, queued in order
  function automatic int predict_branch_results(
      input logic cmd, input logic [7:0] op, input logic [23:0] ops,
      input logic [15:0] pc, input logic [7:0] pb, input logic [15:0] sp,
      input logic [15:0] x, input logic [7:0] rd);
    bus_result_t res [0:3];
    int          n;
    int          nnext;
    logic [15:0] ret;
    logic [15:0] word;
    n = 0;
    if (cmd == CMD_START) begin
      fetch_busy    = 1'b0;
      fetch_count   = 2'd0;
      fetched_bytes = 24'h0;
      case (op)
        OP_JSR_ABS: begin
          ret = pc + 16'd1;
          res[0] = stack_write(sp, ret[15:8]);
          res[1] = stack_write(sp - 16'd1, ret[7:0]);
          res[2] = branch_done(ops[15:0], pb, sp - 16'd2);
          n = 3;
        end
        OP_JSL: begin
          ret = pc + 16'd2;
          res[0] = stack_write(sp, pb);
          res[1] = stack_write(sp - 16'd1, ret[15:8]);
          res[2] = stack_write(sp - 16'd2, ret[7:0]);
          res[3] = branch_done(ops[15:0], ops[23:16], sp - 16'd3);
          n = 4;
        end
        OP_JMP_ABS: begin
          res[0] = branch_done(ops[15:0], pb, sp);
          n = 1;
        end
        OP_JML: begin
          res[0] = branch_done(ops[15:0], ops[23:16], sp);
          n = 1;
        end
        OP_RTS: begin
          res[0] = start_fetch(op, {8'h00, sp + 16'd1}, pb, sp + 16'd2);
          n = 1;
        end
        OP_RTL: begin
          res[0] = start_fetch(op, {8'h00, sp + 16'd1}, pb, sp + 16'd3);
          n = 1;
        end
        OP_JMP_IND, OP_JML_IND: begin
          res[0] = start_fetch(op, {8'h00, ops[15:0]}, pb, sp);
          n = 1;
        end
        OP_JMP_IDX: begin
          res[0] = start_fetch(op, {pb, ops[15:0] + x}, pb, sp);
          n = 1;
        end
        OP_JSR_IDX: begin
          ret = pc + 16'd1;
          res[0] = stack_write(sp, ret[15:8]);
          res[1] = stack_write(sp - 16'd1, ret[7:0]);
          res[2] = start_fetch(op, {pb, ops[15:0] + x}, pb, sp - 16'd2);
          n = 3;
        end
        default: begin
          pend_op = 8'h00;
          res[0] = '0;
          res[0].kind = KIND_ILLEGAL;
          n = 1;
        end
      endcase
    end else if (fetch_busy) begin
      // data byte for the pending pointer fetch
      fetched_bytes = fetched_bytes | ({16'h0, rd} << (8 * fetch_count));
      nnext = fetch_count + 1;
      if (nnext < fetch_length(pend_op)) begin
        fetch_count = nnext[1:0];
        res[0] = bus_read({fetch_ptr[23:16], fetch_ptr[15:0] + nnext[15:0]});
      end else begin
        word = fetched_bytes[15:0];
        fetch_busy  = 1'b0;
        fetch_count = 2'd0;
        case (pend_op)
          OP_RTS:     res[0] = branch_done(word + 16'd1, keep_bank, keep_sp);
          OP_RTL:     res[0] = branch_done(word + 16'd1, fetched_bytes[23:16], keep_sp);
          OP_JML_IND: res[0] = branch_done(word, fetched_bytes[23:16], keep_sp);
          default:    res[0] = branch_done(word, keep_bank, keep_sp);
        endcase
      end
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      expected_bus_results.push_back(res[i]);
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    bus_result_t want;
    if (expected_bus_results.size() == 0) begin
      report_mismatch("result with nothing expected, kind", out_kind, 0);
      return;
    end
    want = expected_bus_results.pop_front();
    if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
    if (out_bus_address !== want.addr) report_mismatch("bus_address", out_bus_address, want.addr);
    if (out_write_byte !== want.wbyte) report_mismatch("write_byte", out_write_byte, want.wbyte);
    if (out_new_pc !== want.pc) report_mismatch("new_pc", out_new_pc, want.pc);
    if (out_new_bank !== want.bank) report_mismatch("new_bank", out_new_bank, want.bank);
    if (out_new_sp !== want.sp) report_mismatch("new_sp", out_new_sp, want.sp);
    if (out_last !== want.last) report_mismatch("last", out_last, want.last);
  endtask

  // result side: check accepted transactions, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // send one transaction, predict its results once accepted
  task automatic send_item(input logic cmd, input logic [7:0] op, input logic [23:0] ops,
                           input logic [15:0] pc, input logic [7:0] pb,
                           input logic [15:0] sp, input logic [15:0] x,
                           input logic [7:0] rd, output int nres);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_opcode          <= op;
    in_operand_bytes   <= ops;
    in_operand_address <= pc;
    in_program_bank    <= pb;
    in_stack_pointer   <= sp;
    in_index_x         <= x;
    in_read_data       <= rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nres = predict_branch_results(cmd, op, ops, pc, pb, sp, x, rd);
  endtask

  task automatic send_start(input logic [7:0] op, input logic [23:0] ops,
                            input logic [15:0] pc, input logic [7:0] pb,
                            input logic [15:0] sp, input logic [15:0] x);
    int nres;
    send_item(CMD_START, op, ops, pc, pb, sp, x, $urandom, nres);
  endtask

  task automatic send_data(input logic [7:0] rd, output int nres);
    send_item(CMD_DATA, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, rd, nres);
  endtask

  task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input int count);
    int nres;
    send_data(b0, nres);
    if (count > 1) send_data(b1, nres);
    if (count > 2) send_data(b2, nres);
  endtask

  // hold the sender until every expected result has arrived
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bus_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'hfffe;
      3: return 16'h0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic is_branch_op(input logic [7:0] op);
    foreach (branch_ops[i]) if (branch_ops[i] == op) return 1'b1;
    return 1'b0;
  endfunction

  // absolute and long jumps and calls, stack and return address wrap
  task automatic test_direct_jumps();
    send_start(OP_JMP_ABS, 24'hffffff, 16'h0000, 8'h00, 16'h0000, 16'hffff);
    send_start(OP_JML, 24'hffffff, 16'hffff, 8'h00, 16'hffff, 16'h0000);
    send_start(OP_JSR_ABS, 24'h00ffff, 16'hffff, 8'hff, 16'h0000, 16'h0000);
    send_start(OP_JSL, 24'hff0000, 16'hfffe, 8'hff, 16'h0001, 16'hffff);
  endtask

  // returns and indirect forms, pointer wrap within the bank
  task automatic test_direct_fetches();
    send_start(OP_RTS, 24'h000000, 16'h1234, 8'h5a, 16'hffff, 16'h0000);
    send_bytes(8'hff, 8'hff, 8'h00, 2);
    send_start(OP_RTL, 24'hffffff, 16'h0000, 8'ha5, 16'hfffe, 16'hffff);
    send_bytes(8'h00, 8'h00, 8'hff, 3);
    send_start(OP_JMP_IND, 24'h00ffff, 16'h8000, 8'h7f, 16'h0100, 16'h0000);
    send_bytes(8'h34, 8'h12, 8'h00, 2);
    send_start(OP_JML_IND, 24'hffffff, 16'h0001, 8'h01, 16'h01ff, 16'hffff);
    send_bytes(8'hff, 8'h80, 8'hfe, 3);
    send_start(OP_JMP_IDX, 24'h00ff00, 16'h4000, 8'hff, 16'h01f0, 16'h0100);
    send_bytes(8'h01, 8'hf0, 8'h00, 2);
  endtask

  // illegal opcodes, stray data, start while a fetch is pending
  task automatic test_open_cases();
    int nres;
    send_start(8'h00, 24'h123456, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    send_data(8'hff, nres);
    send_start(8'hff, 24'h000000, 16'h0000, 8'h00, 16'h0000, 16'h0000);
    send_start(OP_JSR_IDX, 24'hffffff, 16'hffff, 8'h80, 16'h0001, 16'hffff);
    send_data(8'h55, nres);
    send_start(OP_JMP_ABS, 24'habcdef, 16'h2222, 8'h33, 16'h4444, 16'h5555);
  endtask

  // random instructions, mostly complete fetches, some broken or illegal
  task automatic test_random_traffic(input int items, input int idle, input int stall);
    int          sent;
    int          nres;
    int          pick;
    int          need;
    logic [7:0]  op;
    sent = 0;
    idle_pct  = idle;
    stall_pct = stall;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // stray data while nothing is pending counts only if it gets a result
        send_data($urandom, nres);
        if (nres > 0) sent++;
      end else begin
        if (pick < 14) begin
          do op = $urandom; while (is_branch_op(op));
        end else begin
          op = branch_ops[$urandom_range(9)];
        end
        send_start(op, $urandom, pick_word(), $urandom, pick_word(), pick_word());
        sent++;
        if (fetch_busy) begin
          need = fetch_length(pend_op);
          // one in ten fetches is cut short by the next start
          if ($urandom_range(9) == 0) need = $urandom_range(need - 1);
          for (int i = 0; i < need; i++) begin
            send_data($urandom, nres);
            sent++;
          end
        end
      end
    end
  endtask

  // run limit
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_command         <= CMD_START;
    in_opcode          <= 8'h00;
    in_operand_bytes   <= 24'h0;
    in_operand_address <= 16'h0;
    in_program_bank    <= 8'h0;
    in_stack_pointer   <= 16'h0;
    in_index_x         <= 16'h0;
    in_read_data       <= 8'h0;
    out_stall          <= 1'b0;
    pend_op       = 8'h00;
    fetch_busy    = 1'b0;
    fetch_count   = 2'd0;
    fetched_bytes = 24'h0;
    fetch_ptr     = 24'h0;
    keep_bank     = 8'h00;
    keep_sp       = 16'h0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_direct_jumps();
    test_direct_fetches();
    test_open_cases();
    wait_all_results();

    test_random_traffic(120, 0, 0);
    wait_all_results();
    test_random_traffic(115, 51, 0);
    wait_all_results();
    test_random_traffic(115, 0, 51);
    wait_all_results();
    test_random_traffic(120, 25, 25);

    // drain and let any stray result show up
    idle_pct = 0;
    wait_all_results();
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (expected_bus_results.size() != 0)
      report_mismatch("results never returned", expected_bus_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
